### src/lkr_pkg.sv
package lkr_pkg;

  localparam int POOL_FRAMES = 64;
  localparam int K_MAX       = 8;
  localparam int TIME_BITS   = 32;

  localparam int FRAME_W = $clog2(POOL_FRAMES);
  localparam int PTR_W   = $clog2(K_MAX);
  localparam int CNT_W   = $clog2(K_MAX + 1);
  localparam int TOTAL_W = $clog2(POOL_FRAMES + 1);
  localparam int HADDR_W = FRAME_W + PTR_W;
  localparam int K_W     = 4;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [CNT_W-1:0]     CNT_FULL = CNT_W'(K_MAX);
  localparam logic [K_W-1:0]       K_TOP    = K_W'(K_MAX);
  localparam logic [K_W-1:0]       K_RESET  = K_W'(2);

  typedef enum logic [1:0] {
    REQ_ACCESS   = 2'd0,
    REQ_SET_MARK = 2'd1,
    REQ_REMOVE   = 2'd2,
    REQ_EVICT    = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t          req_type;
    logic [FRAME_W-1:0] frame_idx;
    logic               evictable;
  } req_t;

  typedef struct packed {
    logic               evicted_valid;
    logic [FRAME_W-1:0] evicted_frame;
    logic [TOTAL_W-1:0] evictable_count;
  } rsp_t;

  // per-frame bookkeeping; head is the ring slot of the oldest stamp
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             mark;
    logic [PTR_W-1:0] head;
  } meta_t;

  typedef struct packed {
    logic               en;
    logic [FRAME_W-1:0] addr;
    meta_t              data;
  } meta_wr_t;

  typedef struct packed {
    logic                 en;
    logic [HADDR_W-1:0]   addr;
    logic [TIME_BITS-1:0] data;
  } hist_wr_t;

endpackage

### src/lkr_meta_ram.sv
module lkr_meta_ram (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lkr_pkg::meta_wr_t             wr,
  input  logic [lkr_pkg::FRAME_W-1:0]   rd_addr,
  output lkr_pkg::meta_t                rd_meta
);

  lkr_pkg::meta_t mem [lkr_pkg::POOL_FRAMES];
  logic [lkr_pkg::POOL_FRAMES-1:0] vld_r;
  lkr_pkg::meta_t rd_data_r;
  logic           rd_vld_r;

  // storage, registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // valid bits: an unwritten frame reads as all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_meta = rd_vld_r ? rd_data_r : '0;

endmodule

### src/lkr_hist_ram.sv
module lkr_hist_ram (
  input  logic                            clk,
  input  lkr_pkg::hist_wr_t               wr,
  input  logic [lkr_pkg::HADDR_W-1:0]     rd_addr,
  output logic [lkr_pkg::TIME_BITS-1:0]   rd_data
);

  logic [lkr_pkg::TIME_BITS-1:0] mem [lkr_pkg::POOL_FRAMES * lkr_pkg::K_MAX];
  logic [lkr_pkg::TIME_BITS-1:0] rd_data_r;

  // stamp ring per frame, registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### src/lru_k_replacement_policy.sv
// LRU-K victim selection for a pool of buffer frames.
// Input channel: in_valid/in_stall carry one request (record access, set mark,
// remove, evict). Output channel: out_valid/out_stall carry exactly one
// response per request, in order. cfg_wr_en/cfg_wr_data write k, which is
// used as soon as it is registered, also by a request in flight.
// Record, set-mark and remove go from accept to out_valid through a
// metadata read, then update and response. Evict scans every
// frame through a three-stage read pipeline (metadata read, stamp read,
// compare), then commits the victim and loads the response.
// One request is in flight at a time; in_stall is high until its response
// is loaded in the output register, so the next request can be accepted
// while the response waits on a stalled receiver.
// Reset clears all frame metadata at once through valid bits; no clearing
// pass is needed. k returns to 2, the time counter to 0.
// A stalled output holds its response; the block finishes the following
// request internally and waits until the output register frees up.
module lru_k_replacement_policy (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  lkr_pkg::req_t             in_req,
  output logic                      out_valid,
  input  logic                      out_stall,
  output lkr_pkg::rsp_t             out_rsp,
  input  logic                      cfg_wr_en,
  input  logic [lkr_pkg::K_W-1:0]   cfg_wr_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_META,
    ST_SCAN,
    ST_COMMIT,
    ST_RESP
  } state_t;

  state_t state_r;
  lkr_pkg::req_t req_r;
  logic [lkr_pkg::K_W-1:0]       k_r;
  logic [lkr_pkg::TIME_BITS-1:0] time_r;
  logic [lkr_pkg::TOTAL_W-1:0]   total_r;
  lkr_pkg::rsp_t                 res_r;
  logic                          out_valid_r;
  lkr_pkg::rsp_t                 out_rsp_r;

  // scan pipeline
  logic [lkr_pkg::FRAME_W:0]     scan_cnt_r;
  logic                          s1_vld_r;
  logic [lkr_pkg::FRAME_W-1:0]   s1_frame_r;
  logic                          s2_vld_r;
  logic                          s2_cand_r;
  logic                          s2_cls_r;
  logic [lkr_pkg::FRAME_W-1:0]   s2_frame_r;
  logic                          best_vld_r;
  logic                          best_cls_r;
  logic [lkr_pkg::TIME_BITS-1:0] best_key_r;
  logic [lkr_pkg::FRAME_W-1:0]   best_frame_r;

  lkr_pkg::meta_wr_t             meta_wr;
  logic [lkr_pkg::FRAME_W-1:0]   meta_rd_addr;
  lkr_pkg::meta_t                meta_q;
  lkr_pkg::hist_wr_t             hist_wr;
  logic [lkr_pkg::HADDR_W-1:0]   hist_rd_addr;
  logic [lkr_pkg::TIME_BITS-1:0] hist_q;

  logic                          in_acc;
  logic                          out_free;
  logic [lkr_pkg::K_W-1:0]       k_eff;
  logic [lkr_pkg::TIME_BITS-1:0] time_inc;
  logic                          s1_cand;
  logic                          s1_cls;
  logic [lkr_pkg::CNT_W-1:0]     s1_back;
  logic [lkr_pkg::PTR_W-1:0]     s1_phys;
  logic                          s2_better;
  logic                          meta_full;

  lkr_meta_ram u_meta (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (meta_wr),
    .rd_addr (meta_rd_addr),
    .rd_meta (meta_q)
  );

  lkr_hist_ram u_hist (
    .clk     (clk),
    .wr      (hist_wr),
    .rd_addr (hist_rd_addr),
    .rd_data (hist_q)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // clamp k into 1..K_MAX
  always_comb begin
    if (k_r == '0) begin
      k_eff = lkr_pkg::K_W'(1);
    end else if (k_r > lkr_pkg::K_TOP) begin
      k_eff = lkr_pkg::K_TOP;
    end else begin
      k_eff = k_r;
    end
  end

  assign time_inc  = (time_r == lkr_pkg::TIME_MAX) ? time_r : time_r + 1'b1;
  assign meta_full = (meta_q.cnt == lkr_pkg::CNT_FULL);

  // metadata read address
  always_comb begin
    case (state_r)
      ST_IDLE: meta_rd_addr = in_req.frame_idx;
      ST_SCAN: meta_rd_addr = scan_cnt_r[lkr_pkg::FRAME_W-1:0];
      default: meta_rd_addr = '0;
    endcase
  end

  // scan stage 1: classify frame, locate its key stamp
  always_comb begin
    s1_cand = (meta_q.cnt != '0) && meta_q.mark;
    s1_cls  = (lkr_pkg::K_W'(meta_q.cnt) >= k_eff);
    s1_back = s1_cls ? meta_q.cnt - lkr_pkg::CNT_W'(k_eff) : '0;
    s1_phys = meta_q.head + s1_back[lkr_pkg::PTR_W-1:0];
  end
  assign hist_rd_addr = {s1_frame_r, s1_phys};

  // scan stage 2: strict compare keeps the lowest frame on ties
  assign s2_better = s2_cand_r &&
                     (!best_vld_r || (s2_cls_r < best_cls_r) ||
                      ((s2_cls_r == best_cls_r) && (hist_q < best_key_r)));

  // memory writes
  always_comb begin
    meta_wr = '0;
    hist_wr = '0;
    if (state_r == ST_META) begin
      meta_wr.addr = req_r.frame_idx;
      meta_wr.data = meta_q;
      hist_wr.addr = {req_r.frame_idx,
                      meta_full ? meta_q.head : meta_q.cnt[lkr_pkg::PTR_W-1:0]};
      hist_wr.data = time_inc;
      case (req_r.req_type)
        lkr_pkg::REQ_ACCESS: begin
          meta_wr.en = 1'b1;
          hist_wr.en = 1'b1;
          if (meta_full) begin
            meta_wr.data.head = meta_q.head + 1'b1;
          end else begin
            meta_wr.data.cnt = meta_q.cnt + 1'b1;
          end
        end
        lkr_pkg::REQ_SET_MARK: begin
          meta_wr.en        = (meta_q.cnt != '0);
          meta_wr.data.mark = req_r.evictable;
        end
        lkr_pkg::REQ_REMOVE: begin
          meta_wr.en   = (meta_q.cnt != '0) && meta_q.mark;
          meta_wr.data = '0;
        end
        default: begin
          meta_wr.en = 1'b0;
        end
      endcase
    end else if (state_r == ST_COMMIT) begin
      meta_wr.en   = best_vld_r;
      meta_wr.addr = best_frame_r;
      meta_wr.data = '0;
    end
  end

  // sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= lkr_pkg::K_RESET;
      time_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      scan_cnt_r  <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      best_vld_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        k_r <= cfg_wr_data;
      end
      // a response loaded in ST_RESP takes over the output register
      if (out_valid_r && !out_stall && state_r != ST_RESP) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            req_r      <= in_req;
            scan_cnt_r <= '0;
            best_vld_r <= 1'b0;
            s1_vld_r   <= 1'b0;
            s2_vld_r   <= 1'b0;
            if (in_req.req_type == lkr_pkg::REQ_EVICT) begin
              state_r <= ST_SCAN;
            end else begin
              state_r <= ST_META;
            end
          end
        end
        ST_META: begin
          res_r.evicted_valid <= 1'b0;
          res_r.evicted_frame <= '0;
          case (req_r.req_type)
            lkr_pkg::REQ_ACCESS: begin
              time_r <= time_inc;
              res_r.evictable_count <= total_r;
            end
            lkr_pkg::REQ_SET_MARK: begin
              if (meta_q.cnt != '0 && meta_q.mark && !req_r.evictable) begin
                total_r <= total_r - 1'b1;
                res_r.evictable_count <= total_r - 1'b1;
              end else if (meta_q.cnt != '0 && !meta_q.mark && req_r.evictable) begin
                total_r <= total_r + 1'b1;
                res_r.evictable_count <= total_r + 1'b1;
              end else begin
                res_r.evictable_count <= total_r;
              end
            end
            lkr_pkg::REQ_REMOVE: begin
              if (meta_q.cnt != '0 && meta_q.mark && total_r != '0) begin
                total_r <= total_r - 1'b1;
                res_r.evictable_count <= total_r - 1'b1;
              end else begin
                res_r.evictable_count <= total_r;
              end
            end
            default: begin
              res_r.evictable_count <= total_r;
            end
          endcase
          state_r <= ST_RESP;
        end
        ST_SCAN: begin
          s1_vld_r   <= !scan_cnt_r[lkr_pkg::FRAME_W];
          s1_frame_r <= scan_cnt_r[lkr_pkg::FRAME_W-1:0];
          if (!scan_cnt_r[lkr_pkg::FRAME_W]) begin
            scan_cnt_r <= scan_cnt_r + 1'b1;
          end
          s2_vld_r   <= s1_vld_r;
          s2_cand_r  <= s1_vld_r && s1_cand;
          s2_cls_r   <= s1_cls;
          s2_frame_r <= s1_frame_r;
          if (s2_vld_r && s2_better) begin
            best_vld_r   <= 1'b1;
            best_cls_r   <= s2_cls_r;
            best_key_r   <= hist_q;
            best_frame_r <= s2_frame_r;
          end
          if (scan_cnt_r[lkr_pkg::FRAME_W] && !s1_vld_r && !s2_vld_r) begin
            state_r <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          res_r.evicted_valid <= best_vld_r;
          res_r.evicted_frame <= best_vld_r ? best_frame_r : '0;
          if (best_vld_r && total_r != '0) begin
            total_r <= total_r - 1'b1;
            res_r.evictable_count <= total_r - 1'b1;
          end else begin
            res_r.evictable_count <= total_r;
          end
          state_r <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_rsp_r   <= res_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // a request is never accepted twice in a row
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in flight");

  // no victim means frame zero
  a_no_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rsp.evicted_valid) |-> (out_rsp.evicted_frame == '0))
    else $error("frame reported without a victim");

  // evictable count bounded by the frame pool
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= lkr_pkg::TOTAL_W'(lkr_pkg::POOL_FRAMES))
    else $error("evictable count exceeds frame pool");

  // a victim only comes from an evict request
  a_victim_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_META) |=> !res_r.evicted_valid)
    else $error("victim reported for a non-evict request");

endmodule
